// File: rtl/pdzv_pkg.sv
// ----------------------------------------------------------------------------
// pdzv_pkg
// Shared types and constants for the point delta / zigzag / varint encoder.
// ----------------------------------------------------------------------------
package pdzv_pkg;

  // Largest point count a begin item may carry
  localparam logic [9:0] MaxPoints = 10'd512;

  // Reset value of the byte capacity register
  localparam logic [15:0] CapReset = 16'hFFFF;

  // Varint continuation bit
  localparam logic [7:0] ContBit = 8'h80;

  // Input command codes
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  // One input item
  typedef struct packed {
    logic               cmd;
    logic        [9:0]  point_count;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       error;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BYTE,
    ST_ERR
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch accepted item
    logic emit_byte;  // push current varint group
    logic shift;      // move to next 7-bit group
    logic next_val;   // switch to the y delta
    logic commit;     // item done, update feature state
    logic emit_err;   // push error result, set sticky fault
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic load_err;   // item rejected at acceptance
    logic cap_full;   // no capacity left for the next byte
    logic more;       // current value needs further groups
    logic pending;    // y delta still to send
    logic slot_free;  // output register can take a result
  } dp_sts_t;

  // Zigzag map of a 32-bit two's-complement delta
  function automatic logic [31:0] zigzag(input logic [31:0] d);
    zigzag = {d[30:0], 1'b0} ^ {32{d[31]}};
  endfunction

endpackage

// File: rtl/point_delta_zigzag_varint_encoder_unit.sv
// ----------------------------------------------------------------------------
// point_delta_zigzag_varint_encoder_unit
// Polyline/polygon encoder: delta, zigzag and LEB128 varint byte stream.
// ----------------------------------------------------------------------------
// Works on one item at a time. An accepted item is latched and its deltas
// computed, then its result bytes go out through the output register: a
// begin item gives 1 or 2 bytes, a point item 2 to 10 bytes. Within an
// item the single output register sets the rate at one byte per cycle
// while out_stall is low. Rejected items and faults give one error result;
// after a fault every item gives one error result until reset. The capacity
// register may be written whenever no item is in flight and applies from
// the next byte.
module point_delta_zigzag_varint_encoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pdzv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pdzv_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);
  import pdzv_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequencer
  pdzv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  pdzv_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// File: rtl/pdzv_ctrl.sv
// ----------------------------------------------------------------------------
// pdzv_ctrl
// Sequencer: accepts one item, then steps the datapath byte by byte.
// ----------------------------------------------------------------------------
module pdzv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pdzv_pkg::dp_sts_t   sts,
  output pdzv_pkg::ctrl_cmd_t cmd
);
  import pdzv_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = sts.load_err ? ST_ERR : ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (sts.slot_free) begin
          if (sts.cap_full || (!sts.more && !sts.pending)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = accept;
      end
      ST_BYTE: begin
        if (sts.slot_free) begin
          if (sts.cap_full) begin
            cmd.emit_err = 1'b1;
          end else begin
            cmd.emit_byte = 1'b1;
            if (sts.more) begin
              cmd.shift = 1'b1;
            end else if (sts.pending) begin
              cmd.next_val = 1'b1;
            end else begin
              cmd.commit = 1'b1;
            end
          end
        end
      end
      ST_ERR: begin
        cmd.emit_err = sts.slot_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/pdzv_dpath.sv
// ----------------------------------------------------------------------------
// pdzv_dpath
// Feature state, delta/zigzag values, varint shifter and output register.
// ----------------------------------------------------------------------------
module pdzv_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pdzv_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pdzv_pkg::out_item_t   out_data,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  pdzv_pkg::ctrl_cmd_t   cmd,
  output pdzv_pkg::dp_sts_t     sts
);
  import pdzv_pkg::*;

  // Control state
  logic [15:0] cap_r;
  logic [15:0] bytes_used_r, bytes_used_nxt;
  logic [9:0]  points_left_r, points_left_nxt;
  logic        failed_r, failed_nxt;
  logic        pending_r, pending_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Payload
  logic [31:0] prev_x_r, prev_x_nxt;
  logic [31:0] prev_y_r, prev_y_nxt;
  logic [31:0] new_x_r, new_y_r;
  logic [31:0] val_r, val_nxt;
  logic [31:0] pend_r;
  logic        cmd_r;
  logic [9:0]  count_r;
  out_item_t   out_item_r, out_item_nxt;

  logic        bad_begin;
  logic        last_byte;

  // Item checks at acceptance
  assign bad_begin = (points_left_r != 10'd0) || (in_data.point_count == 10'd0)
                  || (in_data.point_count > MaxPoints);

  always_comb begin
    sts.load_err  = failed_r || ((in_data.cmd == CMD_BEGIN) ? bad_begin
                                                            : (points_left_r == 10'd0));
    sts.cap_full  = (bytes_used_r >= cap_r);
    sts.more      = (val_r[31:7] != 25'd0);
    sts.pending   = pending_r;
    sts.slot_free = !out_valid_r || !out_stall;
  end

  assign last_byte = !sts.more && !pending_r;

  // Next-value logic
  always_comb begin
    bytes_used_nxt  = bytes_used_r;
    points_left_nxt = points_left_r;
    failed_nxt      = failed_r;
    pending_nxt     = pending_r;
    prev_x_nxt      = prev_x_r;
    prev_y_nxt      = prev_y_r;
    val_nxt         = val_r;
    out_item_nxt    = out_item_r;
    out_valid_nxt   = out_valid_r && out_stall;

    if (cmd.load) begin
      if (in_data.cmd == CMD_BEGIN) begin
        val_nxt     = {22'd0, in_data.point_count};
        pending_nxt = 1'b0;
      end else begin
        val_nxt     = zigzag(in_data.x_coord - prev_x_r);
        pending_nxt = 1'b1;
      end
    end

    // Varint group out
    if (cmd.emit_byte) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.out_byte     = {sts.more, val_r[6:0]};
      out_item_nxt.last_of_item = last_byte;
      out_item_nxt.error        = 1'b0;
      bytes_used_nxt            = bytes_used_r + 16'd1;
    end
    if (cmd.shift) begin
      val_nxt = {7'd0, val_r[31:7]};
    end
    if (cmd.next_val) begin
      val_nxt     = pend_r;
      pending_nxt = 1'b0;
    end

    // Feature bookkeeping once all bytes of the item are out
    if (cmd.commit) begin
      if (cmd_r == CMD_BEGIN) begin
        points_left_nxt = count_r;
        prev_x_nxt      = 32'd0;
        prev_y_nxt      = 32'd0;
      end else begin
        points_left_nxt = points_left_r - 10'd1;
        prev_x_nxt      = new_x_r;
        prev_y_nxt      = new_y_r;
      end
    end

    // Error result, fault is sticky
    if (cmd.emit_err) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '{out_byte: 8'd0, last_of_item: 1'b1, error: 1'b1};
      failed_nxt    = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r         <= CapReset;
      bytes_used_r  <= '0;
      points_left_r <= '0;
      failed_r      <= 1'b0;
      pending_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      prev_x_r      <= '0;
      prev_y_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      bytes_used_r  <= bytes_used_nxt;
      points_left_r <= points_left_nxt;
      failed_r      <= failed_nxt;
      pending_r     <= pending_nxt;
      out_valid_r   <= out_valid_nxt;
      prev_x_r      <= prev_x_nxt;
      prev_y_r      <= prev_y_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    out_item_r <= out_item_nxt;
    if (cmd.load) begin
      cmd_r   <= in_data.cmd;
      count_r <= in_data.point_count;
      new_x_r <= in_data.x_coord;
      new_y_r <= in_data.y_coord;
      pend_r  <= zigzag(in_data.y_coord - prev_y_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
